>>> hw/rtl/htd_pkg.sv
// Shared types and constants for the Huffman tree decoder.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package htd_pkg;

   // Field widths of one request and one response.
   localparam int CODE_W = 16;
   localparam int LEN_W  = 5;
   localparam int SYM_W  = 8;
   localparam int BYTE_W = 8;
   localparam int KIND_W = 2;

   // Longest code that an insert walks; longer lengths are cut down to it.
   localparam int MAX_CODE_LEN = 16;

   // Request tdata layout, lowest bit first.
   localparam int CODE_LO    = 0;
   localparam int LEN_LO     = CODE_LO + CODE_W;
   localparam int SYM_LO     = LEN_LO + LEN_W;
   localparam int BYTE_LO    = SYM_LO + SYM_W;
   localparam int REQ_DATA_W = 40;

   // Request opcodes, carried in req_tuser.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // Response kinds, carried in rsp_tuser.
   localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              accept;      // latch request, set up the walk
      logic              follow;      // step to the existing child, read it
      logic              create;      // allocate a child and link it
      logic              write_leaf;  // mark the current node as a leaf
      logic              restart;     // rewind the insert walk to the root
      logic              go_root;     // return the decode walk to the root
      logic              save_walk;   // store the decode position
      logic              set_halt;    // raise the sticky decode halt
      logic              push;        // queue a result
      logic [KIND_W-1:0] push_kind;
      logic              flush;       // send the held result as the last one
   } htd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rem_zero;    // no code or data bits left
      logic missing;     // the child on the current bit does not exist
      logic sym_hit;     // decode walk has just arrived at a leaf
      logic full;        // remaining code bits need more nodes than are free
      logic can_push;    // a result can be queued this cycle
      logic pend_valid;  // a result is held back waiting for its successor
      logic out_free;    // the output register can load this cycle
      logic halted;      // sticky decode halt
   } htd_status_type;

endpackage

>>> hw/rtl/htd_ctrl.sv
// Controller state machine of the Huffman tree decoder.
// Drives the datapath through htd_cmd_type and reads htd_status_type.
// Depends on htd_pkg.
module htd_ctrl import htd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           req_opcode,
   input  htd_status_type status,
   output htd_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_INS_SCAN = 3'd1;
   localparam logic [2:0] ST_INS_CHK  = 3'd2;
   localparam logic [2:0] ST_INS_WALK = 3'd3;
   localparam logic [2:0] ST_DEC_BIT  = 3'd4;
   localparam logic [2:0] ST_FLUSH    = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.push_kind = KIND_SYMBOL;
      req_tready    = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_opcode == OP_INSERT) begin
                  state_in = ST_INS_SCAN;
               end else if (!status.halted) begin
                  state_in = ST_DEC_BIT;
               end
            end
         end
         // First pass: find where the existing path ends.
         ST_INS_SCAN: begin
            if (status.rem_zero || status.missing) begin
               state_in = ST_INS_CHK;
            end else begin
               cmd.follow = 1'b1;
            end
         end
         ST_INS_CHK: begin
            if (status.full) begin
               cmd.push      = 1'b1;
               cmd.push_kind = KIND_FULL;
               state_in      = ST_FLUSH;
            end else begin
               cmd.restart = 1'b1;
               state_in    = ST_INS_WALK;
            end
         end
         // Second pass: follow the path and build the missing part.
         ST_INS_WALK: begin
            if (status.rem_zero) begin
               cmd.write_leaf = 1'b1;
               cmd.push       = 1'b1;
               cmd.push_kind  = KIND_DONE;
               state_in       = ST_FLUSH;
            end else if (status.missing) begin
               cmd.create = 1'b1;
            end else begin
               cmd.follow = 1'b1;
            end
         end
         // One data bit per cycle while a result can be queued; a leaf reached on the
         // previous step is reported while the next bit starts again from the root.
         ST_DEC_BIT: begin
            if (status.rem_zero) begin
               if (status.sym_hit) begin
                  if (status.can_push) begin
                     cmd.push      = 1'b1;
                     cmd.go_root   = 1'b1;
                     cmd.save_walk = 1'b1;
                     state_in      = ST_FLUSH;
                  end
               end else begin
                  cmd.save_walk = 1'b1;
                  state_in      = ST_FLUSH;
               end
            end else if (status.sym_hit) begin
               if (status.can_push) begin
                  cmd.push    = 1'b1;
                  cmd.go_root = 1'b1;
                  cmd.follow  = !status.missing;
               end
            end else if (status.missing) begin
               if (status.can_push) begin
                  cmd.push      = 1'b1;
                  cmd.push_kind = KIND_ERROR;
                  cmd.set_halt  = 1'b1;
                  cmd.go_root   = 1'b1;
                  cmd.save_walk = 1'b1;
                  state_in      = ST_FLUSH;
               end
            end else begin
               cmd.follow = 1'b1;
            end
         end
         // Send the held result with the last flag set.
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/htd_datapath.sv
// Datapath of the Huffman tree decoder: node table, walk pointers, node
// count, held result and output register. Controlled by htd_ctrl.
// Depends on htd_pkg.
module htd_datapath import htd_pkg::*; #(
   parameter int NODES = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  htd_cmd_type           cmd,
   output htd_status_type        status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_opcode,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SYM_W-1:0]      rsp_tdata,
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int PTR_W    = $clog2(NODES);
   localparam int CNT_W    = $clog2(NODES + 1);
   localparam int SUM_W    = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
   // Node entry: symbol, leaf flag, left child, right child (lowest first).
   localparam int LEAF_B   = SYM_W;
   localparam int LEFT_LO  = SYM_W + 1;
   localparam int RIGHT_LO = LEFT_LO + PTR_W;
   localparam int ENTRY_W  = RIGHT_LO + PTR_W;

   // Node table; the root lives in flip-flops so that reset can empty it.
   logic [ENTRY_W-1:0] mem [NODES];
   logic [ENTRY_W-1:0] mem_q_ff;
   logic [ENTRY_W-1:0] root_ff, root_in;

   logic               op_ff;
   logic [CODE_W-1:0]  code_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [SYM_W-1:0]   sym_ff;
   logic [BYTE_W-1:0]  byte_ff;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [PTR_W-1:0]   np_ff, np_in;
   logic [PTR_W-1:0]   walk_ff, walk_in;
   logic               fresh_ff, fresh_in;
   logic               arrived_ff, arrived_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               halted_ff, halted_in;

   logic               pend_valid_ff, pend_valid_in;
   logic [KIND_W-1:0]  pend_kind_ff, pend_kind_in;
   logic [SYM_W-1:0]   pend_sym_ff, pend_sym_in;
   logic               out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]  out_kind_ff, out_kind_in;
   logic [SYM_W-1:0]   out_sym_ff, out_sym_in;
   logic               out_last_ff, out_last_in;

   logic [LEN_W-1:0]   field_len;
   logic [LEN_W-1:0]   len_clamped;
   logic [ENTRY_W-1:0] cur;
   logic [ENTRY_W-1:0] eff;
   logic               sym_hit;
   logic [LEN_W-1:0]   bit_idx;
   logic               code_bit;
   logic               step_bit;
   logic [PTR_W-1:0]   child;
   logic [PTR_W-1:0]   new_idx;
   logic [ENTRY_W-1:0] link_entry;
   logic [ENTRY_W-1:0] leaf_entry;
   logic [ENTRY_W-1:0] wr_data;
   logic               wr_en;
   logic               rd_en;
   logic [PTR_W-1:0]   rd_addr;
   logic               out_free;
   logic               out_load;
   logic [SYM_W-1:0]   push_sym;
   logic               full;

   // Request length, cut down to the longest code walked.
   assign field_len   = req_tdata[LEN_LO +: LEN_W];
   assign len_clamped = ({1'b0, field_len} > (LEN_W + 1)'(MAX_CODE_LEN)) ?
                        LEN_W'(MAX_CODE_LEN) : field_len;

   // Current node and the node the next bit steps from.
   assign cur     = fresh_ff ? '0 : ((np_ff == '0) ? root_ff : mem_q_ff);
   assign sym_hit = (op_ff == OP_DECODE) && arrived_ff && cur[LEAF_B];
   assign eff     = sym_hit ? root_ff : cur;

   // Bit under the walk: code bits above the field width read as zero.
   assign bit_idx  = rem_ff - LEN_W'(1);
   assign code_bit = (bit_idx < LEN_W'(CODE_W)) ? code_ff[bit_idx[3:0]] : 1'b0;
   assign step_bit = (op_ff == OP_DECODE) ? byte_ff[bit_idx[2:0]] : code_bit;
   assign child    = step_bit ? eff[RIGHT_LO +: PTR_W] : eff[LEFT_LO +: PTR_W];
   assign new_idx  = count_ff[PTR_W-1:0];

   // Capacity check for the nodes that the insert still has to create.
   assign full = (SUM_W'(count_ff) + SUM_W'(rem_ff)) > SUM_W'(NODES);

   // Entry updates for linking a new child and for marking a leaf.
   always_comb begin
      link_entry = cur;
      if (step_bit) begin
         link_entry[RIGHT_LO +: PTR_W] = new_idx;
      end else begin
         link_entry[LEFT_LO +: PTR_W] = new_idx;
      end
      leaf_entry              = cur;
      leaf_entry[LEAF_B]      = 1'b1;
      leaf_entry[SYM_W-1:0]   = sym_ff;
   end

   assign wr_data = cmd.write_leaf ? leaf_entry : link_entry;
   assign wr_en   = (cmd.create || cmd.write_leaf) && (np_ff != '0);
   assign rd_en   = cmd.accept || cmd.follow;
   assign rd_addr = cmd.accept ? walk_ff : child;

   // Node table write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[np_ff] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   // Walk pointers, counters and the root entry.
   always_comb begin
      root_in    = root_ff;
      rem_in     = rem_ff;
      np_in      = np_ff;
      walk_in    = walk_ff;
      fresh_in   = fresh_ff;
      arrived_in = arrived_ff;
      count_in   = count_ff;
      halted_in  = halted_ff || cmd.set_halt;
      if ((cmd.create || cmd.write_leaf) && (np_ff == '0)) begin
         root_in = wr_data;
      end
      if (cmd.accept) begin
         np_in      = (req_opcode == OP_DECODE) ? walk_ff : '0;
         rem_in     = (req_opcode == OP_DECODE) ? LEN_W'(BYTE_W) : len_clamped;
         fresh_in   = 1'b0;
         arrived_in = 1'b0;
      end
      if (cmd.restart) begin
         np_in    = '0;
         rem_in   = len_ff;
         fresh_in = 1'b0;
      end
      if (cmd.go_root) begin
         np_in      = '0;
         arrived_in = 1'b0;
      end
      if (cmd.follow) begin
         np_in      = child;
         rem_in     = rem_ff - LEN_W'(1);
         arrived_in = 1'b1;
      end
      if (cmd.create) begin
         np_in    = new_idx;
         rem_in   = rem_ff - LEN_W'(1);
         fresh_in = 1'b1;
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.save_walk) begin
         walk_in = cmd.go_root ? '0 : np_ff;
      end
   end

   // Results: one is held back so that the last flag can be set on the
   // final result of a request.
   assign out_free = !out_valid_ff || rsp_tready;
   assign push_sym = (cmd.push_kind == KIND_SYMBOL) ? cur[SYM_W-1:0] : '0;
   assign out_load = (cmd.push || cmd.flush) && pend_valid_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_sym_in   = pend_sym_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_sym_in    = out_sym_ff;
      out_last_in   = out_last_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_kind_in  = pend_kind_ff;
         out_sym_in   = pend_sym_ff;
         out_last_in  = cmd.flush;
      end
      if (cmd.push) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = cmd.push_kind;
         pend_sym_in   = push_sym;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff       <= '0;
         np_ff         <= '0;
         walk_ff       <= '0;
         fresh_ff      <= 1'b0;
         arrived_ff    <= 1'b0;
         count_ff      <= CNT_W'(1);
         halted_ff     <= 1'b0;
         rem_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         root_ff       <= root_in;
         np_ff         <= np_in;
         walk_ff       <= walk_in;
         fresh_ff      <= fresh_in;
         arrived_ff    <= arrived_in;
         count_ff      <= count_in;
         halted_ff     <= halted_in;
         rem_ff        <= rem_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_opcode;
         code_ff <= req_tdata[CODE_LO +: CODE_W];
         len_ff  <= len_clamped;
         sym_ff  <= req_tdata[SYM_LO +: SYM_W];
         byte_ff <= req_tdata[BYTE_LO +: BYTE_W];
      end
      pend_kind_ff <= pend_kind_in;
      pend_sym_ff  <= pend_sym_in;
      out_kind_ff  <= out_kind_in;
      out_sym_ff   <= out_sym_in;
      out_last_ff  <= out_last_in;
   end

   // Status back to the controller.
   always_comb begin
      status.rem_zero   = (rem_ff == '0);
      status.missing    = (child == '0);
      status.sym_hit    = sym_hit;
      status.full       = full;
      status.can_push   = !pend_valid_ff || out_free;
      status.pend_valid = pend_valid_ff;
      status.out_free   = out_free;
      status.halted     = halted_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sym_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> hw/rtl/huffman_tree_decoder.sv
// Channel  | Dir | tdata                                    | tuser        | tlast
// req      | in  | code_bits, code_len, symbol, data_byte   | opcode       | -
// rsp      | out | out_symbol                               | kind         | last
//
// An insert runs accept, a scan of the path that exists already, a capacity check,
// a walk that builds the missing nodes, and flush; a full table skips that walk.
// A decode byte runs accept, one node-table read per data bit, a final leaf check
// and flush. A decode after a decode error is taken with no response; reset empties
// the root, no pass. A stalled rsp side holds one result at the output and one
// inside; the walk waits.
module huffman_tree_decoder import htd_pkg::*; #(
   parameter int NODES = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // code_bits[15:0], code_len[20:16], symbol[28:21], data_byte[36:29], zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[0]
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_symbol[7:0]
   output logic [SYM_W-1:0]      rsp_tdata,
   // kind[1:0]
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);

   htd_cmd_type    cmd;
   htd_status_type status;

   // Sequencer for insert and decode walks.
   htd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser[0]),
      .status     (status),
      .cmd        (cmd)
   );

   // Node table, pointers and result registers.
   htd_datapath #(
      .NODES (NODES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_opcode (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> hw/rtl/htd_checker.sv
// Port-level checks for the Huffman tree decoder, bound to the top level.
// Depends on htd_pkg and huffman_tree_decoder.
module htd_checker import htd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [0:0]        req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [SYM_W-1:0]  rsp_tdata,
   input logic [KIND_W-1:0] rsp_tuser,
   input logic              rsp_tlast
);

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // Only a decoded symbol carries a nonzero symbol byte.
   a_sym_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_SYMBOL) |-> (rsp_tdata == '0))
      else $error("symbol byte set on a non-symbol response");

   // Insert results and decode errors always end their request.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == KIND_DONE) || (rsp_tuser == KIND_FULL) ||
                     (rsp_tuser == KIND_ERROR)) |-> rsp_tlast)
      else $error("final response without last");

   // An insert keeps the controller busy once it is taken, so the next request waits.
   a_insert_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == OP_INSERT) |=> !req_tready)
      else $error("request taken right after an insert");

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (.*);

>>> verif/huffman_tree_decoder_test.sv
// Self-checking testbench for the Huffman tree decoder: builds code trees, decodes streams.
// A local copy of the code tree predicts every response, with random idling on both channels.
// Depends on htd_pkg and huffman_tree_decoder only.
`timescale 1ns / 1ps

module huffman_tree_decoder_test;
   import htd_pkg::*;

   localparam int TREE_NODES  = 512;
   localparam int IDLE_PCT    = 17;
   localparam int HOLD_AT     = 30;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 60;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic                opcode;
      logic [CODE_W-1:0]   code_bits;
      logic [LEN_W-1:0]    code_len;
      logic [SYM_W-1:0]    symbol;
      logic [BYTE_W-1:0]   data_byte;
   } tree_req_type;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [SYM_W-1:0]  symbol;
      logic              last;
   } tree_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SYM_W-1:0]      rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;

   // Local copy of the code tree; a child index of zero means no child.
   int                    node_left [TREE_NODES];
   int                    node_right[TREE_NODES];
   bit                    node_is_leaf[TREE_NODES];
   logic [SYM_W-1:0]      node_sym[TREE_NODES];
   int                    nodes_used;
   int                    walk_node;
   bit                    decode_halted;

   tree_req_type          req_backlog[$];
   tree_rsp_type          awaited_rsp[$];
   tree_req_type          cur_req;
   tree_req_type          next_req;
   logic [REQ_DATA_W-1:0] req_word;
   logic                  req_taken = 1'b0;

   int                    queued_count = 0;
   int                    accepted_count = 0;
   int                    insert_count = 0;
   int                    decode_count = 0;
   int                    rsp_count = 0;
   int                    full_count = 0;
   int                    error_count = 0;
   int                    mismatches = 0;
   int                    cycle_count = 0;
   int                    hold_left = 0;
   bit                    hold_done = 1'b0;
   wire                   steady = accepted_count >= 45 && accepted_count < 70;

   huffman_tree_decoder #(.NODES(TREE_NODES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic int child_of_node(int p, bit b);
      return b ? node_right[p] : node_left[p];
   endfunction

   // Insert: count the new nodes first, then walk and create them if they fit.
   function automatic void tree_insert(tree_req_type r);
      int len;
      int need;
      int p;
      int c;
      tree_rsp_type res;
      len = int'(r.code_len);
      need = 0;
      p = 0;
      if (len > MAX_CODE_LEN) len = MAX_CODE_LEN;
      for (int i = len - 1; i >= 0; i--) begin
         c = child_of_node(p, r.code_bits[i]);
         if (c == 0) begin
            need = i + 1;
            break;
         end
         p = c;
      end
      res.symbol = '0;
      res.last = 1'b1;
      if (nodes_used + need > TREE_NODES) begin
         res.kind = KIND_FULL;
         full_count++;
      end else begin
         p = 0;
         for (int i = len - 1; i >= 0; i--) begin
            c = child_of_node(p, r.code_bits[i]);
            if (c == 0) begin
               c = nodes_used;
               nodes_used++;
               node_left[c] = 0;
               node_right[c] = 0;
               node_is_leaf[c] = 1'b0;
               node_sym[c] = '0;
               if (r.code_bits[i]) node_right[p] = c;
               else node_left[p] = c;
            end
            p = c;
         end
         node_is_leaf[p] = 1'b1;
         node_sym[p] = r.symbol;
         res.kind = KIND_DONE;
      end
      awaited_rsp.insert(awaited_rsp.size(), res);
   endfunction

   // Decode: walk the byte MSB first; a leaf emits its symbol, a missing child halts.
   function automatic void tree_decode(tree_req_type r);
      int p;
      int c;
      tree_rsp_type res;
      tree_rsp_type batch[$];
      if (decode_halted) return;
      p = walk_node;
      res.last = 1'b0;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         c = child_of_node(p, r.data_byte[i]);
         if (c == 0) begin
            res.kind = KIND_ERROR;
            res.symbol = '0;
            batch.insert(batch.size(), res);
            decode_halted = 1'b1;
            error_count++;
            p = 0;
            break;
         end
         p = c;
         if (node_is_leaf[p]) begin
            res.kind = KIND_SYMBOL;
            res.symbol = node_sym[p];
            batch.insert(batch.size(), res);
            p = 0;
         end
      end
      walk_node = p;
      if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) awaited_rsp.insert(awaited_rsp.size(), batch[i]);
   endfunction

   function automatic void add_insert(int code, int len, int sym);
      tree_req_type r;
      r.opcode = OP_INSERT;
      r.code_bits = CODE_W'(code);
      r.code_len = LEN_W'(len);
      r.symbol = SYM_W'(sym);
      r.data_byte = BYTE_W'($urandom_range(255));
      req_backlog.insert(req_backlog.size(), r);
      queued_count++;
   endfunction

   function automatic void add_decode(int data);
      tree_req_type r;
      r.opcode = OP_DECODE;
      r.code_bits = CODE_W'($urandom);
      r.code_len = LEN_W'($urandom_range(31));
      r.symbol = SYM_W'($urandom_range(255));
      r.data_byte = BYTE_W'(data);
      req_backlog.insert(req_backlog.size(), r);
      queued_count++;
   endfunction

   // Builds encoded bytes by walking the current tree from the current decode position.
   // Normally only existing children are taken, so the stream stays well formed; when
   // aiming for an error the walk takes the first missing child it meets and stops there.
   function automatic void add_walk_bytes(int nbytes, bit aim_error);
      int p;
      bit b;
      bit hit;
      bit bits[$];
      logic [BYTE_W-1:0] data;
      p = walk_node;
      hit = 1'b0;
      while (bits.size() < nbytes * BYTE_W && !hit) begin
         if (node_left[p] == 0 || node_right[p] == 0) begin
            b = (node_left[p] == 0) ^ aim_error;
            hit = aim_error;
         end else begin
            b = 1'($urandom_range(1));
         end
         bits.insert(bits.size(), b);
         if (!hit) begin
            p = child_of_node(p, b);
            if (node_is_leaf[p]) p = 0;
         end
      end
      if (aim_error) begin
         while (bits.size() % BYTE_W != 0) bits.insert(bits.size(), 1'($urandom_range(1)));
      end
      for (int k = 0; k + BYTE_W <= bits.size(); k += BYTE_W) begin
         for (int i = 0; i < BYTE_W; i++) data[BYTE_W - 1 - i] = bits[k + i];
         add_decode(int'(data));
      end
   endfunction

   function automatic void add_random_insert();
      int len;
      case ($urandom_range(9))
         0: len = MAX_CODE_LEN;
         1: len = $urandom_range(31, MAX_CODE_LEN + 1);
         default: len = $urandom_range(8, 1);
      endcase
      add_insert($urandom_range(16'hFFFF), len, $urandom_range(255));
   endfunction

   // Waits until every queued request is accepted and every predicted response is in.
   task automatic wait_drained();
      while (accepted_count != queued_count || awaited_rsp.size() != 0) @(posedge clock);
   endtask

   // Request side: drives a new transfer at the falling edge once the previous one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            next_req = req_backlog.pop_front();
            req_word = '0;
            req_word[CODE_LO +: CODE_W] = next_req.code_bits;
            req_word[LEN_LO +: LEN_W] = next_req.code_len;
            req_word[SYM_LO +: SYM_W] = next_req.symbol;
            req_word[BYTE_LO +: BYTE_W] = next_req.data_byte;
            cur_req <= next_req;
            req_tdata <= req_word;
            req_tuser <= next_req.opcode;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response side: random backpressure plus one long hold-off to fill the block up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || $urandom_range(99) >= IDLE_PCT;
      end
   end

   // Rising edge: predict on each accepted request, compare each accepted response.
   always @(posedge clock) begin
      tree_rsp_type exp_rsp;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, awaited_rsp.size());
         $display("Test completed with failures");
         $finish;
      end
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            if (cur_req.opcode == OP_INSERT) begin
               tree_insert(cur_req);
               insert_count++;
            end else begin
               tree_decode(cur_req);
               decode_count++;
            end
            accepted_count <= accepted_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (awaited_rsp.size() == 0) begin
               $error("response with nothing expected: kind %0d symbol %0h last %0b",
                      rsp_tuser, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               exp_rsp = awaited_rsp.pop_front();
               if (rsp_tuser !== exp_rsp.kind) begin
                  $error("kind: expected %0d, got %0d", exp_rsp.kind, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata !== exp_rsp.symbol) begin
                  $error("out_symbol: expected %0h, got %0h", exp_rsp.symbol, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== exp_rsp.last) begin
                  $error("last: expected %0b, got %0b", exp_rsp.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      int rounds;
      foreach (node_left[i]) begin
         node_left[i] = 0;
         node_right[i] = 0;
         node_is_leaf[i] = 1'b0;
         node_sym[i] = '0;
      end
      nodes_used = 1;
      walk_node = 0;
      decode_halted = 1'b0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Base code: 00, 01, 10, 1100, 111 and one long code under 1101.
      add_insert(16'h0000, 2, 8'h00);
      add_insert(16'h0001, 2, 8'hFF);
      add_insert(16'h0002, 2, 8'h5A);
      add_insert(16'h000C, 4, 8'hA5);
      add_insert(16'hD555, 16, 8'h3C);
      add_insert(16'h0007, 3, 8'hC3);
      // Three symbols, then a byte that ends mid-code and emits nothing.
      add_decode(8'h1B);
      add_decode(8'h55);
      add_decode(8'h56);
      add_decode(8'h00);
      // Turning an inner node into a leaf gives eight symbols from one byte.
      add_insert(16'hFFFE, 1, 8'h81);
      add_decode(8'h00);
      add_decode(8'hFF);
      // Empty code, over-long codes and paths extended below existing leaves.
      add_insert(16'hFFFF, 0, 8'h77);
      add_insert(16'hFFFF, 20, 8'h12);
      add_insert(16'hFFFA, 3, 8'h34);
      add_insert(16'h8000, 31, 8'hEE);
      add_decode(8'h00);
      add_decode(8'h3F);
      wait_drained();

      // Random inserts, then well-formed streams over the grown tree.
      for (rounds = 0; rounds < 3; rounds++) begin
         repeat (4) add_random_insert();
         wait_drained();
         add_walk_bytes(10, 1'b0);
         wait_drained();
      end

      // Noise bytes, then a stream steered into a missing child if still running.
      repeat (8) add_decode($urandom_range(255));
      wait_drained();
      if (!decode_halted) add_walk_bytes(64, 1'b1);
      wait_drained();
      repeat (3) add_decode($urandom_range(255));
      wait_drained();

      // Long codes until the node table overflows a few times.
      for (rounds = 0; rounds < 16 && full_count < 3; rounds++) begin
         repeat (6) add_insert($urandom_range(16'hFFFF), MAX_CODE_LEN, $urandom_range(255));
         wait_drained();
      end
      // An existing path needs no new node, so it still fits in a full table.
      add_insert(16'h0000, 2, 8'h99);
      add_random_insert();
      wait_drained();

      repeat (SETTLE) @(posedge clock);
      if (awaited_rsp.size() != 0) begin
         $error("%0d responses never arrived", awaited_rsp.size());
         mismatches++;
      end
      $display("Covered %0d requests (%0d inserts, %0d decodes) and %0d responses,",
               accepted_count, insert_count, decode_count, rsp_count);
      $display("with %0d table-full outcomes, %0d decode errors and %0d tree nodes used.",
               full_count, error_count, nodes_used);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
